[src/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cdq_cmd_t;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL_REJ  = 2'd1;
  localparam logic [1:0] ST_EMPTY_REJ = 2'd2;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CFG_W   = 5;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_FETCH = 4'b1000
  } cdq_state_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic look;
    logic load;
  } cdq_ctl_t;

endpackage

`default_nettype wire

[src/cdq_ctrl.sv]
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cdq_ctl_t      ctl
);

  cdq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready = (state_r == S_IDLE);
    ctl.take = in_valid && (state_r == S_IDLE);
    ctl.exec = (state_r == S_EXEC);
    ctl.look = (state_r == S_LOOK);
    ctl.load = (state_r == S_FETCH) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (ctl.take) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_FETCH;
      S_FETCH: if (ctl.load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/cdq_dp.sv]
`default_nettype none

module cdq_dp
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cdq_ctl_t                   ctl,
  input  wire logic [1:0]                 in_command,
  input  wire logic signed [FIELD_W-1:0]  in_data_in,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_W-1:0]           cfg_wr_data,
  output logic [1:0]                      out_status,
  output logic signed [FIELD_W-1:0]       out_popped_value,
  output logic signed [FIELD_W-1:0]       out_front_value,
  output logic signed [FIELD_W-1:0]       out_rear_value,
  output logic                            out_is_empty,
  output logic                            out_is_full
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  cdq_cmd_t              cmd_r;
  logic [DATA_WIDTH-1:0] din_r;
  logic [IDX_W-1:0]      front_r, front_nxt;
  logic [IDX_W-1:0]      rear_r, rear_nxt;
  logic                  empty_r, empty_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  pop_ok_r, pop_ok_nxt;
  logic [DATA_WIDTH-1:0] popped_r;
  logic [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  logic [IDX_W-1:0]      rd_a_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic                  full_now;
  logic [63:0]           din_wide;

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] i, logic [CAP_W-1:0] cap);
    logic [IDX_W:0] s;
    s = {1'b0, i} + 1'b1;
    return (s >= (IDX_W + 1)'(cap)) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(logic [IDX_W-1:0] i, logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] top;
    top = cap - 1'b1;
    return (i == '0) ? IDX_W'(top) : i - 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(logic [DATA_WIDTH-1:0] w);
    logic [63:0] t;
    t = 64'(w);
    return t[FIELD_W-1:0];
  endfunction

  assign din_wide = {32'b0, in_data_in};
  assign full_now = !empty_r && (wrap_inc(rear_r, cap_r) == front_r);

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr_en && empty_r) begin
      priority if (cfg_wr_data == '0) begin
        cap_nxt = CAP_W'(1);
      end else if (32'(cfg_wr_data) > DEPTH) begin
        cap_nxt = CAP_W'(DEPTH);
      end else begin
        cap_nxt = CAP_W'(cfg_wr_data);
      end
    end
  end

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    if (ctl.exec) begin
      status_nxt = ST_DONE;
      pop_ok_nxt = 1'b0;
      unique case (cmd_r)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          priority if (full_now) begin
            status_nxt = ST_FULL_REJ;
          end else if (empty_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = '0;
          end else if (cmd_r == CMD_PUSH_FRONT) begin
            front_nxt = wrap_dec(front_r, cap_r);
            wr_en     = 1'b1;
            wr_addr   = front_nxt;
          end else begin
            rear_nxt = wrap_inc(rear_r, cap_r);
            wr_en    = 1'b1;
            wr_addr  = rear_nxt;
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          priority if (empty_r) begin
            status_nxt = ST_EMPTY_REJ;
          end else begin
            pop_ok_nxt = 1'b1;
            priority if (front_r == rear_r) begin
              empty_nxt = 1'b1;
            end else if (cmd_r == CMD_POP_FRONT) begin
              front_nxt = wrap_inc(front_r, cap_r);
            end else begin
              rear_nxt = wrap_dec(rear_r, cap_r);
            end
          end
        end
        default: status_nxt = ST_DONE;
      endcase
    end
  end

  assign rd_a_addr = (ctl.exec && cmd_r == CMD_POP_REAR) ? rear_r : front_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= din_r;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rear_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
      cap_r   <= CAP_W'(DEPTH);
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_ok_r <= pop_ok_nxt;
    if (ctl.take) begin
      cmd_r <= cdq_cmd_t'(in_command);
      din_r <= din_wide[DATA_WIDTH-1:0];
    end
    if (ctl.look) begin
      popped_r <= pop_ok_r ? rd_a_r : '0;
    end
    if (ctl.load) begin
      out_status       <= status_r;
      out_popped_value <= to_field(popped_r);
      out_front_value  <= empty_r ? '1 : to_field(rd_a_r);
      out_rear_value   <= empty_r ? '1 : to_field(rd_b_r);
      out_is_empty     <= empty_r;
      out_is_full      <= full_now;
    end
  end

endmodule

`default_nettype wire

[src/circular_double_ended_queue.sv]
// An accepted command steps through the execute, lookup and fetch states and waits in
// fetch until any earlier result is taken. One command at a time, set by the sequencer
//   stepping the registered read ports; a new one is taken while a result waits.
// Reset (synchronous, rst_n low): deque empty, indices zero, capacity DEPTH, no result.
// Slot contents are not cleared; only written slots reach the outputs.
`default_nettype none

module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_command,
  input  wire logic signed [FIELD_W-1:0]  in_data_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic signed [FIELD_W-1:0]       out_popped_value,
  output logic signed [FIELD_W-1:0]       out_front_value,
  output logic signed [FIELD_W-1:0]       out_rear_value,
  output logic                            out_is_empty,
  output logic                            out_is_full,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_W-1:0]           cfg_wr_data
);

  cdq_ctl_t ctl;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  cdq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .in_command       (in_command),
    .in_data_in       (in_data_in),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

endmodule

`default_nettype wire

[src/cdq_checker.sv]
`default_nettype none

module cdq_props
  import cdq_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [1:0]                 out_status,
  input wire logic signed [FIELD_W-1:0]  out_popped_value,
  input wire logic signed [FIELD_W-1:0]  out_front_value,
  input wire logic signed [FIELD_W-1:0]  out_rear_value,
  input wire logic                       out_is_empty,
  input wire logic                       out_is_full
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_popped_value) && $stable(out_front_value))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == '1 && out_rear_value == '1
      && !out_is_full)
    else $error("empty result with bad front, rear or full flag");

  a_reject_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_popped_value == '0)
    else $error("rejected command reports a popped value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_DONE || out_status == ST_FULL_REJ
      || out_status == ST_EMPTY_REJ)
    else $error("undefined status code");

endmodule

bind circular_double_ended_queue cdq_props u_cdq_props (.*);

`default_nettype wire

[tb/sv/cdq_checker.sv]
`timescale 1ns / 100ps

module cdq_checker
  import cdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_command,
  input  logic signed [FIELD_W-1:0] in_data_in,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                out_status,
  input  logic signed [FIELD_W-1:0] out_popped_value,
  input  logic signed [FIELD_W-1:0] out_front_value,
  input  logic signed [FIELD_W-1:0] out_rear_value,
  input  logic                      out_is_empty,
  input  logic                      out_is_full,
  input  logic                      cfg_wr_en,
  input  logic [CFG_W-1:0]          cfg_wr_data,
  output int                        fail_count,
  output int                        pending
);

  localparam int unsigned SLOTS = 16;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] popped;
    logic [FIELD_W-1:0] front;
    logic [FIELD_W-1:0] rear;
    logic               empty;
    logic               full;
  } deque_report_t;

  deque_report_t reports_due[$];
  deque_report_t due_report;
  deque_report_t seen_report;

  logic [FIELD_W-1:0] slot_words [SLOTS];
  int unsigned        front_pos;
  int unsigned        rear_pos;
  bit                 vacant;
  logic [CFG_W-1:0]   cap_setting;
  int                 bad_count;

  initial begin
    bad_count = 0;
  end

  function automatic int unsigned live_cap();
    int unsigned c;
    c = cap_setting;
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  function automatic int unsigned step_up(int unsigned i, int unsigned cap);
    return (i + 1 >= cap) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned i, int unsigned cap);
    return (i == 0) ? cap - 1 : i - 1;
  endfunction

  function automatic bit at_capacity(int unsigned cap);
    return !vacant && step_up(rear_pos, cap) == front_pos;
  endfunction

  function automatic deque_report_t apply_command(logic [1:0] cmd, logic [FIELD_W-1:0] word);
    deque_report_t r;
    int unsigned   cap;
    cap      = live_cap();
    r        = '0;
    r.status = ST_DONE;
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      if (at_capacity(cap)) begin
        r.status = ST_FULL_REJ;
      end else if (vacant) begin
        front_pos      = 0;
        rear_pos       = 0;
        vacant         = 1'b0;
        slot_words[0]  = word;
      end else if (cmd == CMD_PUSH_FRONT) begin
        front_pos             = step_down(front_pos, cap);
        slot_words[front_pos] = word;
      end else begin
        rear_pos             = step_up(rear_pos, cap);
        slot_words[rear_pos] = word;
      end
    end else begin
      if (vacant) begin
        r.status = ST_EMPTY_REJ;
      end else if (cmd == CMD_POP_FRONT) begin
        r.popped = slot_words[front_pos];
        if (front_pos == rear_pos) vacant = 1'b1;
        else front_pos = step_up(front_pos, cap);
      end else begin
        r.popped = slot_words[rear_pos];
        if (front_pos == rear_pos) vacant = 1'b1;
        else rear_pos = step_down(rear_pos, cap);
      end
    end
    r.front = vacant ? '1 : slot_words[front_pos];
    r.rear  = vacant ? '1 : slot_words[rear_pos];
    r.empty = vacant;
    r.full  = at_capacity(cap);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      front_pos   = 0;
      rear_pos    = 0;
      vacant      = 1'b1;
      cap_setting = CFG_W'(SLOTS);
      reports_due.delete();
    end else begin
      if (cfg_wr_en && vacant) cap_setting = cfg_wr_data;

      if (out_valid && out_ready) begin
        seen_report.status = out_status;
        seen_report.popped = out_popped_value;
        seen_report.front  = out_front_value;
        seen_report.rear   = out_rear_value;
        seen_report.empty  = out_is_empty;
        seen_report.full   = out_is_full;
        if (reports_due.size() == 0) begin
          bad_count++;
          if (bad_count <= MAX_REPORTED)
            $display("%0t: unexpected result transfer: status %0d popped %0d",
                     $realtime, out_status, out_popped_value);
        end else begin
          due_report = reports_due.pop_front();
          if (due_report.status !== seen_report.status ||
              due_report.popped !== seen_report.popped ||
              due_report.front  !== seen_report.front  ||
              due_report.rear   !== seen_report.rear   ||
              due_report.empty  !== seen_report.empty  ||
              due_report.full   !== seen_report.full) begin
            bad_count++;
            if (bad_count <= MAX_REPORTED) begin
              $display("%0t: expected status %0d popped %0d front %0d rear %0d e %0b f %0b",
                       $realtime, due_report.status, $signed(due_report.popped),
                       $signed(due_report.front), $signed(due_report.rear),
                       due_report.empty, due_report.full);
              $display("%0t: actual   status %0d popped %0d front %0d rear %0d e %0b f %0b",
                       $realtime, seen_report.status, $signed(seen_report.popped),
                       $signed(seen_report.front), $signed(seen_report.rear),
                       seen_report.empty, seen_report.full);
            end
          end
        end
      end

      if (in_valid && in_ready)
        reports_due.push_back(apply_command(in_command, in_data_in));
    end
    fail_count <= bad_count;
    pending    <= reports_due.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cdq_pkg::*;

  localparam int SLOTS          = 16;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 140;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_command = CMD_PUSH_FRONT;
  logic signed [FIELD_W-1:0] in_data_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_status;
  logic signed [FIELD_W-1:0] out_popped_value;
  logic signed [FIELD_W-1:0] out_front_value;
  logic signed [FIELD_W-1:0] out_rear_value;
  logic                      out_is_empty;
  logic                      out_is_full;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]          cfg_wr_data = '0;

  int      fail_count;
  int      pending;
  int      idle_cycles;
  bit [1:0] pace = 2'd2;
  bit      rx_hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circular_double_ended_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  cdq_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  function automatic int draw_gap();
    case (pace)
      2'd0:    return 0;
      2'd1:    return $urandom_range(0, 3);
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(logic [1:0] cmd, logic [FIELD_W-1:0] word);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_data_in <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pop();
    send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR, pick_word());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(int push_pct, int phase);
    int i;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if (phase == 3 && i == 20) rx_hold_req = 1'b1;
      if (phase == 5 && i == 60) drain_results();
      if ($urandom_range(0, 99) < push_pct)
        send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, pick_word());
      else
        send_pop();
    end
    repeat (SLOTS + 1) send_pop();
  endtask

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("circular_double_ended_queue verification failed");
    $finish;
  end

  initial begin
    int caps [PHASES];
    int pushes [3];
    int p;
    caps   = '{16, 1, 0, 2, 31, 17, 3, 16, 7, 0, 16, 5};
    pushes = '{70, 50, 35};
    caps[9] = $urandom_range(1, SLOTS);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(CMD_POP_FRONT, 32'h1234_5678);
    send_command(CMD_POP_REAR, '1);
    send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_command(CMD_PUSH_REAR, 32'h8000_0000);
    send_command(CMD_PUSH_FRONT, '1);
    send_command(CMD_PUSH_REAR, '0);
    send_command(CMD_PUSH_FRONT, 32'h5555_5555);
    send_command(CMD_PUSH_REAR, 32'hAAAA_AAAA);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_POP_REAR, '0);
    send_command(CMD_POP_FRONT, '0);

    drain_results();
    write_capacity(CFG_W'(2));
    send_command(CMD_PUSH_REAR, 32'h0000_0001);
    drain_results();
    write_capacity(CFG_W'(31));
    send_command(CMD_PUSH_FRONT, 32'h0000_0002);
    send_command(CMD_PUSH_REAR, 32'h0000_0003);
    send_command(CMD_POP_REAR, '1);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_FRONT, '0);

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      write_capacity(CFG_W'(caps[p]));
      pace = 2'(p % 3);
      run_phase(pushes[p % 3], p);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("circular_double_ended_queue verification clean");
    end else begin
      $display("circular_double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
